// ===== sv/fatan2_pkg.sv =====
// shared constants and types for the four-quadrant arctangent pipeline
// no dependencies; used by the channel interfaces and the top level
package fatan2_pkg;

   localparam int IN_WIDTH_DEF = 16;
   localparam int ANGLE_WIDTH  = 16;

   // ratio magnitude is unsigned q15 in 0..32768
   localparam int QUOT_WIDTH   = 16;
   localparam int DIV_STAGES   = QUOT_WIDTH;

   // polynomial intermediate widths
   localparam int P_WIDTH      = 14;
   localparam int T_WIDTH      = 14;
   localparam int F_WIDTH      = 14;

   // q15 coefficients
   localparam int K_PI_4_Q15   = 25736;
   localparam int K_C1_Q15     = 8018;
   localparam int K_C2_Q15     = 2173;
   localparam int K_ONE_Q15    = 32768;
   localparam int K_HALF_Q15   = 16384;
   localparam int K_HALF_Q17   = 65536;

   // q13 angles
   localparam int K_PI_2_Q13   = 12868;
   localparam int K_PI_Q13     = 25736;

   typedef struct packed {
      logic xneg;
      logic yneg;
      logic swap;
      logic num_nz;
      logic den_zero;
   } side_type;

endpackage

// ===== sv/fatan2_req_if.sv =====
// request channel: one vector word (x, y) with valid/ready
// depends on fatan2_pkg for the default width
interface fatan2_req_if #(
   parameter int IN_WIDTH = fatan2_pkg::IN_WIDTH_DEF
);
   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] coord_x;
   logic signed [IN_WIDTH-1:0] coord_y;

   modport source (output valid, output coord_x, output coord_y, input ready);
   modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

// ===== sv/fatan2_rsp_if.sv =====
// response channel: one q13 angle word with valid/ready
// depends on fatan2_pkg for the angle width
interface fatan2_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [fatan2_pkg::ANGLE_WIDTH-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

// ===== sv/fast_atan2_approximation.sv =====
// four-quadrant atan2 estimate, fully pipelined, 21 register stages
// throughput: one word per cycle unless rsp_chan.ready stalls the pipeline;
//   the 16-step restoring divider, one quotient bit per stage, sets the depth,
//   followed by three multiplier stages and a fixup
// reset: synchronous, clears every stage valid bit; data registers are not reset
module fast_atan2_approximation #(
   parameter int IN_WIDTH = fatan2_pkg::IN_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   fatan2_req_if.sink           req_chan,
   fatan2_rsp_if.source         rsp_chan
);
   import fatan2_pkg::*;

   localparam int W       = IN_WIDTH;
   localparam int S_PREP  = 0;
   localparam int S_POLYP = DIV_STAGES + 1;
   localparam int S_POLYT = DIV_STAGES + 2;
   localparam int S_POLYF = DIV_STAGES + 3;
   localparam int S_OUT   = DIV_STAGES + 4;
   localparam int NS      = S_OUT + 1;

   // stage control
   logic [NS-1:0] valid_ff;
   logic [NS:0]   adv;
   side_type      side_ff [NS];

   always_comb begin
      adv[NS] = rsp_chan.ready;
      for (int i = NS - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_chan.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_chan.valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // prep stage: magnitudes, octant swap, divider operands
   logic [W-1:0] raw_x, raw_y, mag_x, mag_y, num_in, den_in;
   side_type     side_in;

   always_comb begin
      raw_x            = req_chan.coord_x;
      raw_y            = req_chan.coord_y;
      mag_x            = raw_x[W-1] ? (~raw_x + W'(1)) : raw_x;
      mag_y            = raw_y[W-1] ? (~raw_y + W'(1)) : raw_y;
      side_in.xneg     = raw_x[W-1];
      side_in.yneg     = raw_y[W-1];
      side_in.swap     = mag_y > mag_x;
      num_in           = side_in.swap ? mag_x : mag_y;
      den_in           = side_in.swap ? mag_y : mag_x;
      side_in.num_nz   = num_in != '0;
      side_in.den_zero = den_in == '0;
   end

   // side info rides along with every stage
   always_ff @(posedge clock) begin
      if (adv[S_PREP]) begin
         side_ff[S_PREP] <= side_in;
      end
      for (int i = 1; i < NS; i++) begin
         if (adv[i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   logic [W-1:0]          den_ff [DIV_STAGES+1];
   logic [W-1:0]          rem_ff [DIV_STAGES+1];
   logic [QUOT_WIDTH-1:0] quo_ff [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (adv[S_PREP]) begin
         den_ff[0]       <= den_in;
         rem_ff[0]       <= num_in;
         quo_ff[0]       <= '0;
      end
   end

   // restoring divider, one quotient bit per stage, msb (weight 2^15) first
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      logic [W:0]   trial;
      logic         take;
      logic [W:0]   diff;
      logic [W-1:0] rem_in;

      always_comb begin
         if (k == 1) begin
            trial = {1'b0, rem_ff[k-1]};
         end else begin
            trial = {rem_ff[k-1], 1'b0};
         end
         diff   = trial - {1'b0, den_ff[k-1]};
         take   = trial >= {1'b0, den_ff[k-1]};
         rem_in = take ? diff[W-1:0] : trial[W-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            den_ff[k] <= den_ff[k-1];
            rem_ff[k] <= rem_in;
            quo_ff[k] <= {quo_ff[k-1][QUOT_WIDTH-2:0], take};
         end
      end
   end

   // polynomial: p = c1 + round(c2 * a)
   logic [QUOT_WIDTH-1:0] a_p_ff, a_t_ff;
   logic [P_WIDTH-1:0]    p_ff;
   logic [26:0]           c2_sum;
   logic [P_WIDTH-1:0]    p_in;

   always_comb begin
      c2_sum = 27'(quo_ff[DIV_STAGES]) * 27'(K_C2_Q15) + 27'(K_HALF_Q15);
      p_in   = P_WIDTH'(K_C1_Q15) + P_WIDTH'(c2_sum[26:15]);
   end

   always_ff @(posedge clock) begin
      if (adv[S_POLYP]) begin
         a_p_ff <= quo_ff[DIV_STAGES];
         p_ff   <= p_in;
      end
   end

   // t = round((1 - a) * p)
   logic [T_WIDTH-1:0]    t_ff;
   logic [QUOT_WIDTH-1:0] one_minus;
   logic [28:0]           t_sum;

   always_comb begin
      one_minus = QUOT_WIDTH'(17'(K_ONE_Q15) - 17'(a_p_ff));
      t_sum     = 29'(one_minus) * 29'(p_ff) + 29'(K_HALF_Q15);
   end

   always_ff @(posedge clock) begin
      if (adv[S_POLYT]) begin
         a_t_ff <= a_p_ff;
         t_ff   <= t_sum[28:15];
      end
   end

   // f = round(a * (pi/4 + t)) in q13
   logic [F_WIDTH-1:0] f_ff;
   logic [15:0]        coef_sum;
   logic [31:0]        f_sum;

   always_comb begin
      coef_sum = 16'(K_PI_4_Q15) + 16'(t_ff);
      f_sum    = 32'(a_t_ff) * 32'(coef_sum) + 32'(K_HALF_Q17);
   end

   always_ff @(posedge clock) begin
      if (adv[S_POLYF]) begin
         f_ff <= f_sum[30:17];
      end
   end

   // quadrant fixup
   localparam logic signed [ANGLE_WIDTH-1:0] PI_2 = ANGLE_WIDTH'(K_PI_2_Q13);
   localparam logic signed [ANGLE_WIDTH-1:0] PI   = ANGLE_WIDTH'(K_PI_Q13);

   side_type                       side_f;
   logic signed [ANGLE_WIDTH-1:0]  fz, angle_in, angle_ff;

   always_comb begin
      side_f = side_ff[S_POLYF];
      fz     = $signed({{(ANGLE_WIDTH-F_WIDTH){1'b0}}, f_ff});
      if (side_f.num_nz && (side_f.xneg != side_f.yneg)) begin
         fz = -fz;
      end
      if (side_f.den_zero) begin
         angle_in = '0;
      end else if (side_f.swap) begin
         angle_in = (side_f.yneg ? -PI_2 : PI_2) - fz;
      end else if (side_f.xneg) begin
         angle_in = (side_f.yneg ? -PI : PI) + fz;
      end else begin
         angle_in = fz;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[S_OUT]) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_chan.valid = valid_ff[S_OUT];
   assign rsp_chan.angle = angle_ff;

   // checks
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ($signed(rsp_chan.angle) <= $signed(PI)
                          && $signed(rsp_chan.angle) >= -$signed(PI)))
      else $error("angle out of range");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DIV_STAGES] && !side_ff[DIV_STAGES].den_zero)
         |-> (rem_ff[DIV_STAGES] < den_ff[DIV_STAGES]))
      else $error("divider remainder not below divisor");

   a_swap_ratio: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[S_POLYP] && side_ff[S_POLYP].swap) |-> !a_p_ff[QUOT_WIDTH-1])
      else $error("swapped octant ratio reached one");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid straight after reset");

endmodule
